// ===== rtl/cfb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfb_pkg: shared types, codes and helpers of the CAN frame buffer
// Operation and status codes, frame header layout, stage records and the
// byte-mask and register-packing helpers.
// ----------------------------------------------------------------------------
package cfb_pkg;

  localparam int TX_DEPTH_DEF = 32;
  localparam int RX_DEPTH_DEF = 32;

  localparam int DATA_W      = 64;
  localparam int HDR_W       = 35;
  localparam int ENTRY_W     = HDR_W + DATA_W;
  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 272;

  // operation codes (s_tuser)
  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_TX_DONE = 2'd1;
  localparam logic [1:0] OP_RX_RAW  = 2'd2;
  localparam logic [1:0] OP_RX_POP  = 2'd3;

  // status codes (m_tuser)
  localparam logic [2:0] ST_LOADED    = 3'd0;
  localparam logic [2:0] ST_QUEUED    = 3'd1;
  localparam logic [2:0] ST_TX_DROP   = 3'd2;
  localparam logic [2:0] ST_IDLE      = 3'd3;
  localparam logic [2:0] ST_RX_STORED = 3'd4;
  localparam logic [2:0] ST_RX_DROP   = 3'd5;
  localparam logic [2:0] ST_DELIVERED = 3'd6;
  localparam logic [2:0] ST_EMPTY     = 3'd7;

  localparam logic [3:0] DLC_MAX = 4'd8;

  // frame header: id 28:0, ext 29, rtr 30, length 34:31
  typedef struct packed {
    logic [3:0]  dlc;
    logic        rtr;
    logic        ext;
    logic [28:0] id;
  } hdr_t;

  // one ring entry
  typedef struct packed {
    hdr_t        hdr;
    logic [63:0] data;
  } entry_t;

  // transmit buffer register image
  typedef struct packed {
    logic [31:0] id_regs;
    logic        ext;
    logic [7:0]  dlc_reg;
    logic [63:0] data;
  } tx_regs_t;

  // record handed from the control stage to the result stage
  typedef struct packed {
    logic [2:0]  status;
    logic        tx_from_ram;
    logic        rx_from_ram;
    hdr_t        tx_hdr;
    logic [63:0] tx_data;
    hdr_t        rx_hdr;
    logic [63:0] rx_data;
    logic [31:0] tx_drop_total;
    logic [31:0] rx_drop_total;
  } stage_t;

  // full result of one item
  typedef struct packed {
    logic [2:0]  status;
    tx_regs_t    tx;
    hdr_t        rx_hdr;
    logic [63:0] rx_data;
    logic [31:0] tx_drop_total;
    logic [31:0] rx_drop_total;
  } result_t;

  // keep the first n bytes, all eight for n of eight or more
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[i*8 +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  // pack a frame into SIDH/SIDL/EID8/EID0, length register and data bytes
  function automatic tx_regs_t pack_tx(input hdr_t h, input logic [63:0] d);
    tx_regs_t r;
    r.ext = h.ext;
    if (h.ext) begin
      // SIDL: sid[2:0] at 7:5, extended flag at bit 3, eid[17:16] at 1:0
      r.id_regs = {h.id[28:21], h.id[20:18], 1'b0, 1'b1, 1'b0, h.id[17:16],
                   h.id[15:8], h.id[7:0]};
    end else begin
      r.id_regs = {h.id[10:3], h.id[2:0], 5'b0, 16'h0000};
    end
    r.dlc_reg = {1'b0, h.rtr, 2'b00, h.dlc};
    r.data    = h.rtr ? 64'h0 : (d & byte_mask(h.dlc));
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/can_frame_tx_rx_buffer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted beat passes the stage register, then the output register.
// Throughput: one beat per cycle unless m_tready stalls the output; each beat
// does one read of each ring port and one pointer compare.
// Reset (rst, synchronous): pointers and drop counters to zero, transmit
// buffer marked idle, both stages emptied, s_tready low while in reset;
// ring contents are not cleared.
// ----------------------------------------------------------------------------
// can_frame_tx_rx_buffer_top: CAN frame transmit queue and receive ring
// Sends load the transmit buffer or queue, completions pop the queue, raw
// receive registers are decoded into the ring and pops deliver frames.
// ----------------------------------------------------------------------------
module can_frame_tx_rx_buffer_top #(
  parameter int TX_DEPTH = cfb_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = cfb_pkg::RX_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // frame_id, frame_ext, frame_rtr, frame_dlc, frame_data, raw_id_regs,
  // raw_dlc_reg, zero pad
  input  wire logic [cfb_pkg::IN_TDATA_W-1:0]  s_tdata,
  // operation
  input  wire logic [1:0]                      s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // tx_id_regs, tx_ext, tx_dlc_reg, tx_data, rx_id, rx_ext, rx_rtr, rx_dlc,
  // rx_data, tx_drop_count, rx_drop_count, zero pad
  output logic      [cfb_pkg::OUT_TDATA_W-1:0] m_tdata,
  // status
  output logic      [2:0]                      m_tuser
);

  import cfb_pkg::*;

  logic    advance;
  logic    accept;
  logic    stage_valid;
  stage_t  stage;
  entry_t  tx_rd_entry;
  entry_t  rx_rd_entry;
  result_t result;

  // handshake: output register frees, stage moves, input enters
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !rst && (!stage_valid || advance);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (accept) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= stage_valid;
      end
    end
  end

  cfb_ctrl #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .operation   (s_tuser),
    .frame_id    (s_tdata[28:0]),
    .frame_ext   (s_tdata[29]),
    .frame_rtr   (s_tdata[30]),
    .frame_dlc   (s_tdata[34:31]),
    .frame_data  (s_tdata[98:35]),
    .raw_id_regs (s_tdata[130:99]),
    .raw_dlc_reg (s_tdata[138:131]),
    .stage       (stage),
    .tx_rd_entry (tx_rd_entry),
    .rx_rd_entry (rx_rd_entry)
  );

  cfb_fmt u_fmt (
    .clk         (clk),
    .load        (advance && stage_valid),
    .stage       (stage),
    .tx_rd_entry (tx_rd_entry),
    .rx_rd_entry (rx_rd_entry),
    .result      (result)
  );

  // result beat packing
  assign m_tuser = result.status;
  assign m_tdata = {4'h0,
                    result.rx_drop_total,
                    result.tx_drop_total,
                    result.rx_data,
                    result.rx_hdr.dlc,
                    result.rx_hdr.rtr,
                    result.rx_hdr.ext,
                    result.rx_hdr.id,
                    result.tx.data,
                    result.tx.dlc_reg,
                    result.tx.ext,
                    result.tx.id_regs};

endmodule
`default_nettype wire

// ===== rtl/cfb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfb_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module cfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cfb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfb_ctrl: queue and ring control of the CAN frame buffer
// Decides each beat against the pointers, updates state, writes and reads
// the two rings and registers the stage record.
// ----------------------------------------------------------------------------
module cfb_ctrl #(
  parameter int TX_DEPTH = cfb_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = cfb_pkg::RX_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [1:0]      operation,
  input  wire logic [28:0]     frame_id,
  input  wire logic            frame_ext,
  input  wire logic            frame_rtr,
  input  wire logic [3:0]      frame_dlc,
  input  wire logic [63:0]     frame_data,
  input  wire logic [31:0]     raw_id_regs,
  input  wire logic [7:0]      raw_dlc_reg,
  output cfb_pkg::stage_t      stage,
  output cfb_pkg::entry_t      tx_rd_entry,
  output cfb_pkg::entry_t      rx_rd_entry
);

  import cfb_pkg::*;

  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int RX_AW = $clog2(RX_DEPTH);

  logic [TX_AW-1:0] tx_write_ptr, tx_write_ptr_next;
  logic [TX_AW-1:0] tx_read_ptr, tx_read_ptr_next;
  logic [RX_AW-1:0] rx_write_ptr, rx_write_ptr_next;
  logic [RX_AW-1:0] rx_read_ptr, rx_read_ptr_next;
  logic             tx_buffer_idle, tx_buffer_idle_next;
  logic [31:0]      tx_drop_total, tx_drop_total_next;
  logic [31:0]      rx_drop_total, rx_drop_total_next;

  logic [TX_AW-1:0] tx_wp_inc, tx_rp_inc;
  logic [RX_AW-1:0] rx_wp_inc, rx_rp_inc;
  logic             tx_we, rx_we;
  hdr_t             send_hdr, raw_hdr;
  logic [63:0]      raw_data;
  logic [3:0]       raw_dlc;
  logic [10:0]      raw_sid;
  stage_t           stage_next;

  // pointer increments with wrap at the depth
  assign tx_wp_inc = (tx_write_ptr == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_write_ptr + 1'b1;
  assign tx_rp_inc = (tx_read_ptr  == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_read_ptr  + 1'b1;
  assign rx_wp_inc = (rx_write_ptr == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_write_ptr + 1'b1;
  assign rx_rp_inc = (rx_read_ptr  == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_read_ptr  + 1'b1;

  // header of a frame to send
  assign send_hdr = '{dlc: frame_dlc, rtr: frame_rtr, ext: frame_ext, id: frame_id};

  // decode raw receive registers
  assign raw_sid = {raw_id_regs[31:24], raw_id_regs[23:21]};
  assign raw_dlc = (raw_dlc_reg[3:0] > DLC_MAX) ? DLC_MAX : raw_dlc_reg[3:0];
  always_comb begin
    raw_hdr.ext = raw_id_regs[19];
    raw_hdr.rtr = raw_dlc_reg[6];
    raw_hdr.dlc = raw_dlc;
    if (raw_id_regs[19]) begin
      raw_hdr.id = {raw_sid, raw_id_regs[17:16], raw_id_regs[15:0]};
    end else begin
      raw_hdr.id = {18'h0, raw_sid};
    end
  end
  assign raw_data = frame_data & byte_mask(raw_dlc);

  // decision per beat
  always_comb begin
    tx_write_ptr_next   = tx_write_ptr;
    tx_read_ptr_next    = tx_read_ptr;
    rx_write_ptr_next   = rx_write_ptr;
    rx_read_ptr_next    = rx_read_ptr;
    tx_buffer_idle_next = tx_buffer_idle;
    tx_drop_total_next  = tx_drop_total;
    rx_drop_total_next  = rx_drop_total;
    tx_we               = 1'b0;
    rx_we               = 1'b0;

    stage_next             = stage;
    stage_next.tx_from_ram = 1'b0;
    stage_next.rx_from_ram = 1'b0;
    stage_next.tx_hdr      = send_hdr;
    stage_next.tx_data     = frame_data;
    stage_next.rx_hdr      = raw_hdr;
    stage_next.rx_data     = raw_data;
    stage_next.status      = ST_EMPTY;

    case (operation)
      OP_SEND: begin
        if (tx_buffer_idle) begin
          tx_buffer_idle_next = 1'b0;
          stage_next.status   = ST_LOADED;
        end else if (tx_wp_inc == tx_read_ptr) begin
          tx_drop_total_next = tx_drop_total + 32'd1;
          stage_next.status  = ST_TX_DROP;
        end else begin
          tx_we             = 1'b1;
          tx_write_ptr_next = tx_wp_inc;
          stage_next.status = ST_QUEUED;
        end
      end
      OP_TX_DONE: begin
        if (tx_write_ptr != tx_read_ptr) begin
          tx_read_ptr_next       = tx_rp_inc;
          stage_next.tx_from_ram = 1'b1;
          stage_next.status      = ST_LOADED;
        end else begin
          tx_buffer_idle_next = 1'b1;
          stage_next.status   = ST_IDLE;
        end
      end
      OP_RX_RAW: begin
        if (rx_wp_inc == rx_read_ptr) begin
          rx_drop_total_next = rx_drop_total + 32'd1;
          stage_next.status  = ST_RX_DROP;
        end else begin
          rx_we             = 1'b1;
          rx_write_ptr_next = rx_wp_inc;
          stage_next.status = ST_RX_STORED;
        end
      end
      default: begin
        if (rx_write_ptr != rx_read_ptr) begin
          rx_read_ptr_next       = rx_rp_inc;
          stage_next.rx_from_ram = 1'b1;
          stage_next.status      = ST_DELIVERED;
        end else begin
          stage_next.status = ST_EMPTY;
        end
      end
    endcase

    stage_next.tx_drop_total = tx_drop_total_next;
    stage_next.rx_drop_total = rx_drop_total_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_write_ptr   <= '0;
      tx_read_ptr    <= '0;
      rx_write_ptr   <= '0;
      rx_read_ptr    <= '0;
      tx_buffer_idle <= 1'b1;
      tx_drop_total  <= '0;
      rx_drop_total  <= '0;
    end else if (accept) begin
      tx_write_ptr   <= tx_write_ptr_next;
      tx_read_ptr    <= tx_read_ptr_next;
      rx_write_ptr   <= rx_write_ptr_next;
      rx_read_ptr    <= rx_read_ptr_next;
      tx_buffer_idle <= tx_buffer_idle_next;
      tx_drop_total  <= tx_drop_total_next;
      rx_drop_total  <= rx_drop_total_next;
    end
  end

  // stage record, payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= stage_next;
    end
  end

  // transmit queue; the slot at the read pointer is fetched on every beat
  cfb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (accept && tx_we),
    .waddr (tx_write_ptr),
    .wdata ({send_hdr, frame_data}),
    .re    (accept),
    .raddr (tx_read_ptr),
    .rdata (tx_rd_entry)
  );

  // receive ring
  cfb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (accept && rx_we),
    .waddr (rx_write_ptr),
    .wdata ({raw_hdr, raw_data}),
    .re    (accept),
    .raddr (rx_read_ptr),
    .rdata (rx_rd_entry)
  );

endmodule
`default_nettype wire

// ===== rtl/cfb_fmt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfb_fmt: result stage of the CAN frame buffer
// Picks direct or ring data, packs transmit registers, blanks fields that
// carry no meaning and registers the result.
// ----------------------------------------------------------------------------
module cfb_fmt (
  input  wire logic            clk,
  input  wire logic            load,
  input  wire cfb_pkg::stage_t stage,
  input  wire cfb_pkg::entry_t tx_rd_entry,
  input  wire cfb_pkg::entry_t rx_rd_entry,
  output cfb_pkg::result_t     result
);

  import cfb_pkg::*;

  hdr_t        tx_hdr;
  logic [63:0] tx_data;
  result_t     result_next;

  assign tx_hdr  = stage.tx_from_ram ? tx_rd_entry.hdr  : stage.tx_hdr;
  assign tx_data = stage.tx_from_ram ? tx_rd_entry.data : stage.tx_data;

  // assemble result
  always_comb begin
    result_next               = '0;
    result_next.status        = stage.status;
    result_next.tx_drop_total = stage.tx_drop_total;
    result_next.rx_drop_total = stage.rx_drop_total;
    if (stage.status == ST_LOADED) begin
      result_next.tx = pack_tx(tx_hdr, tx_data);
    end
    if (stage.status inside {ST_RX_STORED, ST_RX_DROP, ST_DELIVERED}) begin
      result_next.rx_hdr  = stage.rx_from_ram ? rx_rd_entry.hdr  : stage.rx_hdr;
      result_next.rx_data = stage.rx_from_ram ? rx_rd_entry.data : stage.rx_data;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cfb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfb_checker: port-level checks of the CAN frame buffer
// Watches the result channel for blanking, clamping and reset behavior.
// ----------------------------------------------------------------------------
module cfb_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [cfb_pkg::OUT_TDATA_W-1:0] m_tdata,
  input wire logic [2:0]                      m_tuser
);

  import cfb_pkg::*;

  // nothing is offered in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // transmit register fields are zero unless a frame was loaded
  a_tx_blank: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_LOADED) |-> (m_tdata[104:0] == '0))
    else $error("tx fields not blank");

  // receive fields are zero unless a frame was stored, dropped or delivered
  a_rx_blank: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_RX_STORED && m_tuser != ST_RX_DROP &&
     m_tuser != ST_DELIVERED) |-> (m_tdata[203:105] == '0))
    else $error("rx fields not blank");

  // delivered length never exceeds eight
  a_rx_dlc: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[139:136] <= DLC_MAX))
    else $error("rx length above eight");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind can_frame_tx_rx_buffer_top cfb_checker u_cfb_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== tb/can_frame_tx_rx_buffer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_frame_tx_rx_buffer_top_tb: self-checking bench for the CAN frame buffer
// Drives send, transmit-done, raw-receive and pop beats with random gaps and
// output stalls. A model of the transmit queue and receive ring predicts every
// result beat, and each beat is compared field by field against it.
// ----------------------------------------------------------------------------
module can_frame_tx_rx_buffer_top_tb;

  localparam int TXQ_DEPTH   = cfb_pkg::TX_DEPTH_DEF;
  localparam int RXR_DEPTH   = cfb_pkg::RX_DEPTH_DEF;
  localparam int ITEM_TARGET = 1700;
  localparam int SETTLE_CYC  = 8;
  localparam int MAX_REPORTS = 10;

  // s_tdata layout, lowest field last
  typedef struct packed {
    logic [4:0]  pad;
    logic [7:0]  raw_dlc_reg;
    logic [31:0] raw_id_regs;
    logic [63:0] frame_data;
    logic [3:0]  frame_dlc;
    logic        frame_rtr;
    logic        frame_ext;
    logic [28:0] frame_id;
  } frame_in_t;

  // m_tdata layout, lowest field last
  typedef struct packed {
    logic [3:0]  pad;
    logic [31:0] rx_drop_count;
    logic [31:0] tx_drop_count;
    logic [63:0] rx_data;
    logic [3:0]  rx_dlc;
    logic        rx_rtr;
    logic        rx_ext;
    logic [28:0] rx_id;
    logic [63:0] tx_data;
    logic [7:0]  tx_dlc_reg;
    logic        tx_ext;
    logic [31:0] tx_id_regs;
  } frame_out_t;

  typedef struct packed {
    logic [2:0] status;
    frame_out_t fields;
  } frame_result_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [cfb_pkg::IN_TDATA_W-1:0] s_tdata;
  logic [1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [cfb_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic [2:0] m_tuser;

  // model state
  cfb_pkg::hdr_t txq_hdr [TXQ_DEPTH];
  logic [63:0]   txq_data[TXQ_DEPTH];
  int            txq_wr, txq_rd;
  logic          txbuf_idle;
  cfb_pkg::hdr_t rxr_hdr [RXR_DEPTH];
  logic [63:0]   rxr_data[RXR_DEPTH];
  int            rxr_wr, rxr_rd;
  logic [31:0]   tx_drop_cnt, rx_drop_cnt;

  frame_result_t pending_results[$];
  int  mismatch_count;
  int  result_count;
  int  beats_sent;
  bit  sender_burst;
  bit  receiver_burst;

  can_frame_tx_rx_buffer_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // keep the first n bytes of d
  function automatic logic [63:0] keep_bytes(input logic [63:0] d, input int n);
    logic [63:0] r;
    r = d;
    for (int i = 0; i < 8; i++) begin
      if (i >= n) r[i*8 +: 8] = 8'h00;
    end
    return r;
  endfunction

  // transmit buffer register image of one frame
  function automatic void fill_tx_regs(input cfb_pkg::hdr_t h, input logic [63:0] d,
                                       inout frame_out_t o);
    logic [10:0] sid;
    logic [17:0] eid;
    if (h.ext) begin
      sid = h.id[28:18];
      eid = h.id[17:0];
      o.tx_id_regs = {sid[10:3], sid[2:0], 2'b01, 1'b0, eid[17:16], eid[15:0]};
    end else begin
      sid = h.id[10:0];
      o.tx_id_regs = {sid[10:3], sid[2:0], 5'b00000, 16'h0000};
    end
    o.tx_ext     = h.ext;
    o.tx_dlc_reg = {1'b0, h.rtr, 2'b00, h.dlc};
    o.tx_data    = h.rtr ? 64'h0 : keep_bytes(d, (h.dlc > cfb_pkg::DLC_MAX) ? 8 : h.dlc);
  endfunction

  // advance the model by one accepted beat and return its result
  function automatic frame_result_t predict_buffer_result(input logic [1:0] op,
                                                          input frame_in_t f);
    frame_result_t r;
    cfb_pkg::hdr_t h;
    logic [63:0]   d;
    logic [7:0]    sidh, sidl;
    int            nxt;
    r = '0;
    case (op)
      cfb_pkg::OP_SEND: begin
        h.id  = f.frame_id;
        h.ext = f.frame_ext;
        h.rtr = f.frame_rtr;
        h.dlc = f.frame_dlc;
        if (txbuf_idle) begin
          txbuf_idle = 1'b0;
          r.status   = cfb_pkg::ST_LOADED;
          fill_tx_regs(h, f.frame_data, r.fields);
        end else begin
          nxt = (txq_wr + 1) % TXQ_DEPTH;
          if (nxt == txq_rd) begin
            tx_drop_cnt++;
            r.status = cfb_pkg::ST_TX_DROP;
          end else begin
            txq_hdr[txq_wr]  = h;
            txq_data[txq_wr] = f.frame_data;
            txq_wr   = nxt;
            r.status = cfb_pkg::ST_QUEUED;
          end
        end
      end
      cfb_pkg::OP_TX_DONE: begin
        if (txq_wr != txq_rd) begin
          r.status = cfb_pkg::ST_LOADED;
          fill_tx_regs(txq_hdr[txq_rd], txq_data[txq_rd], r.fields);
          txq_rd = (txq_rd + 1) % TXQ_DEPTH;
        end else begin
          txbuf_idle = 1'b1;
          r.status   = cfb_pkg::ST_IDLE;
        end
      end
      cfb_pkg::OP_RX_RAW: begin
        sidh  = f.raw_id_regs[31:24];
        sidl  = f.raw_id_regs[23:16];
        h.ext = sidl[3];
        h.rtr = f.raw_dlc_reg[6];
        h.id  = {18'h0, sidh, sidl[7:5]};
        if (h.ext) h.id = {sidh, sidl[7:5], sidl[1:0], f.raw_id_regs[15:0]};
        h.dlc = (f.raw_dlc_reg[3:0] > cfb_pkg::DLC_MAX) ? cfb_pkg::DLC_MAX
                                                         : f.raw_dlc_reg[3:0];
        d     = keep_bytes(f.frame_data, h.dlc);
        nxt   = (rxr_wr + 1) % RXR_DEPTH;
        if (nxt == rxr_rd) begin
          rx_drop_cnt++;
          r.status = cfb_pkg::ST_RX_DROP;
        end else begin
          rxr_hdr[rxr_wr]  = h;
          rxr_data[rxr_wr] = d;
          rxr_wr   = nxt;
          r.status = cfb_pkg::ST_RX_STORED;
        end
        r.fields.rx_id   = h.id;
        r.fields.rx_ext  = h.ext;
        r.fields.rx_rtr  = h.rtr;
        r.fields.rx_dlc  = h.dlc;
        r.fields.rx_data = d;
      end
      default: begin
        if (rxr_wr == rxr_rd) begin
          r.status = cfb_pkg::ST_EMPTY;
        end else begin
          h = rxr_hdr[rxr_rd];
          r.status         = cfb_pkg::ST_DELIVERED;
          r.fields.rx_id   = h.id;
          r.fields.rx_ext  = h.ext;
          r.fields.rx_rtr  = h.rtr;
          r.fields.rx_dlc  = h.dlc;
          r.fields.rx_data = rxr_data[rxr_rd];
          rxr_rd = (rxr_rd + 1) % RXR_DEPTH;
        end
      end
    endcase
    r.fields.tx_drop_count = tx_drop_cnt;
    r.fields.rx_drop_count = rx_drop_cnt;
    return r;
  endfunction

  function automatic frame_in_t send_frame(input logic [28:0] id, input logic ext,
                                           input logic rtr, input logic [3:0] dlc,
                                           input logic [63:0] data);
    frame_in_t f;
    f = '0;
    f.frame_id   = id;
    f.frame_ext  = ext;
    f.frame_rtr  = rtr;
    f.frame_dlc  = dlc;
    f.frame_data = data;
    return f;
  endfunction

  function automatic frame_in_t raw_frame(input logic [31:0] id_regs,
                                          input logic [7:0] dlc_reg,
                                          input logic [63:0] data);
    frame_in_t f;
    f = '0;
    f.raw_id_regs = id_regs;
    f.raw_dlc_reg = dlc_reg;
    f.frame_data  = data;
    return f;
  endfunction

  // every field random, pad zero
  function automatic frame_in_t random_frame();
    frame_in_t f;
    f.pad         = '0;
    f.raw_dlc_reg = 8'($urandom);
    f.raw_id_regs = $urandom;
    f.frame_data  = {$urandom, $urandom};
    f.frame_dlc   = 4'($urandom);
    f.frame_rtr   = 1'($urandom);
    f.frame_ext   = 1'($urandom);
    f.frame_id    = 29'($urandom);
    return f;
  endfunction

  // send one beat after a random gap; valid stays high into the next call
  task automatic drive_frame_beat(input logic [1:0] op, input frame_in_t f);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= f;
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(predict_buffer_result(op, f));
    beats_sent++;
  endtask

  // hold off the sender until every expected result has come back
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("result %0d: %s expected %h got %h", result_count, name, exp_v, act_v);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    frame_result_t e;
    frame_out_t    a;
    if (!rst && m_tvalid && m_tready) begin
      a = m_tdata;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("result %0d: unexpected beat, status %0d", result_count, m_tuser);
      end else begin
        e = pending_results.pop_front();
        check_field("status", e.status, m_tuser);
        check_field("tx_id_regs", e.fields.tx_id_regs, a.tx_id_regs);
        check_field("tx_ext", e.fields.tx_ext, a.tx_ext);
        check_field("tx_dlc_reg", e.fields.tx_dlc_reg, a.tx_dlc_reg);
        check_field("tx_data", e.fields.tx_data, a.tx_data);
        check_field("rx_id", e.fields.rx_id, a.rx_id);
        check_field("rx_ext", e.fields.rx_ext, a.rx_ext);
        check_field("rx_rtr", e.fields.rx_rtr, a.rx_rtr);
        check_field("rx_dlc", e.fields.rx_dlc, a.rx_dlc);
        check_field("rx_data", e.fields.rx_data, a.rx_data);
        check_field("tx_drop_count", e.fields.tx_drop_count, a.tx_drop_count);
        check_field("rx_drop_count", e.fields.rx_drop_count, a.rx_drop_count);
        check_field("pad", e.fields.pad, a.pad);
      end
      result_count++;
    end
  end

  // output side: random stall before each result beat
  initial begin
    int stall;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = receiver_burst ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // extremes of ids and lengths, remote frames, idle completion, empty pop
  task automatic test_directed();
    drive_frame_beat(cfb_pkg::OP_SEND,
                     send_frame(29'h1FFF_FFFF, 1'b0, 1'b0, 4'd8, '1));
    drive_frame_beat(cfb_pkg::OP_SEND,
                     send_frame(29'h1FFF_FFFF, 1'b1, 1'b0, 4'd15, '1));
    drive_frame_beat(cfb_pkg::OP_SEND,
                     send_frame(29'h0, 1'b1, 1'b1, 4'd0, {$urandom, $urandom}));
    drive_frame_beat(cfb_pkg::OP_SEND,
                     send_frame(29'h0, 1'b0, 1'b0, 4'd0, '1));
    repeat (4) drive_frame_beat(cfb_pkg::OP_TX_DONE, '0);
    // completion while already idle
    drive_frame_beat(cfb_pkg::OP_TX_DONE, '0);
    drive_frame_beat(cfb_pkg::OP_SEND,
                     send_frame(29'h155_5555, 1'b0, 1'b1, 4'd5, '1));
    drive_frame_beat(cfb_pkg::OP_TX_DONE, '0);
    drive_frame_beat(cfb_pkg::OP_RX_POP, '0);
    // raw receive: standard, extended remote long, all zero, remote short
    drive_frame_beat(cfb_pkg::OP_RX_RAW, raw_frame(32'hFFE0_0000, 8'h08, '1));
    drive_frame_beat(cfb_pkg::OP_RX_RAW, raw_frame(32'hFFFF_FFFF, 8'hFF, '1));
    drive_frame_beat(cfb_pkg::OP_RX_RAW, raw_frame(32'h0, 8'h00, '1));
    drive_frame_beat(cfb_pkg::OP_RX_RAW,
                     raw_frame({$urandom} | 32'h0008_0000, 8'h43, {$urandom, $urandom}));
    repeat (5) drive_frame_beat(cfb_pkg::OP_RX_POP, '0);
    wait_results_drained();
  endtask

  // fill the transmit queue past full, then drain it back to idle
  task automatic test_tx_queue_overflow();
    sender_burst = 1'b1;
    repeat (TXQ_DEPTH + 2) drive_frame_beat(cfb_pkg::OP_SEND, random_frame());
    sender_burst = 1'b0;
    repeat (TXQ_DEPTH + 1) drive_frame_beat(cfb_pkg::OP_TX_DONE, random_frame());
    wait_results_drained();
  endtask

  // fill the receive ring past full, then pop it empty
  task automatic test_rx_ring_overflow();
    receiver_burst = 1'b1;
    repeat (RXR_DEPTH + 2) drive_frame_beat(cfb_pkg::OP_RX_RAW, random_frame());
    receiver_burst = 1'b0;
    repeat (RXR_DEPTH + 1) drive_frame_beat(cfb_pkg::OP_RX_POP, random_frame());
    wait_results_drained();
  endtask

  // batches of random beats, each batch uniform or leaning toward one operation
  task automatic test_random_traffic();
    int weights[5][4] = '{'{25, 25, 25, 25}, '{70, 10, 10, 10}, '{10, 70, 10, 10},
                          '{10, 10, 70, 10}, '{10, 10, 10, 70}};
    int profile, batch_len, pick, acc;
    logic [1:0] op;
    while (beats_sent < ITEM_TARGET) begin
      profile        = $urandom_range(0, 4);
      batch_len      = $urandom_range(40, 120);
      sender_burst   = ($urandom_range(0, 3) == 0);
      receiver_burst = ($urandom_range(0, 3) == 0);
      repeat (batch_len) begin
        pick = $urandom_range(0, 99);
        acc  = 0;
        op   = cfb_pkg::OP_RX_POP;
        for (int k = 0; k < 4; k++) begin
          acc += weights[profile][k];
          if (pick < acc) begin
            op = 2'(k);
            break;
          end
        end
        drive_frame_beat(op, random_frame());
      end
      if ($urandom_range(0, 3) == 0) wait_results_drained();
    end
    sender_burst   = 1'b0;
    receiver_burst = 1'b0;
  endtask

  // test sequence
  initial begin
    int settle;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = cfb_pkg::OP_SEND;
    txq_wr         = 0;
    txq_rd         = 0;
    txbuf_idle     = 1'b1;
    rxr_wr         = 0;
    rxr_rd         = 0;
    tx_drop_cnt    = '0;
    rx_drop_cnt    = '0;
    mismatch_count = 0;
    result_count   = 0;
    beats_sent     = 0;
    sender_burst   = 1'b0;
    receiver_burst = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_tx_queue_overflow();
    test_rx_ring_overflow();
    test_random_traffic();

    // drain, bounded, then let the pipeline settle
    s_tvalid <= 1'b0;
    settle = 0;
    while (pending_results.size() != 0 && settle < 5000) begin
      @(posedge clk);
      settle++;
    end
    mismatch_count += pending_results.size();
    repeat (SETTLE_CYC) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS can_frame_tx_rx_buffer_top");
    end else begin
      $display("FAIL can_frame_tx_rx_buffer_top");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL can_frame_tx_rx_buffer_top");
    $finish;
  end

endmodule
